// ----- sv/ltp_pkg.sv -----
// Shared types and constants for the log timestamp prefix parser.
// Used by the channel interfaces and every module of the block; depends on nothing.
package ltp_pkg;

   // Line length limit and the reach of the 12-bit content offset.
   localparam int MAX_LINE_LEN = 4096;
   localparam int OFFSET_SPAN  = 4096;
   localparam int OFFSET_LIMIT = (MAX_LINE_LEN < OFFSET_SPAN) ? MAX_LINE_LEN : OFFSET_SPAN;
   localparam int POS_W        = $clog2(OFFSET_LIMIT + 1);

   // Payload widths.
   localparam int BYTE_W   = 8;
   localparam int TS_W     = 64;
   localparam int OFF_W    = 12;
   localparam int STATUS_W = 2;

   // Time conversion constants.
   localparam int SEC_PER_HOUR      = 3600;
   localparam int SEC_PER_MIN       = 60;
   localparam int US_PER_SEC        = 1000000;
   localparam int US_PER_MS         = 1000;
   localparam int MS_DIGITS         = 3;
   localparam int CLOCK_FIELD_LIMIT = 60;

   localparam int H_MULT_W  = $clog2(SEC_PER_HOUR + 1);
   localparam int US_MULT_W = $clog2(US_PER_SEC + 1);
   localparam int CNT_W     = $clog2(US_MULT_W);
   localparam int HIDX_W    = $clog2(H_MULT_W);
   localparam logic [H_MULT_W-1:0]  HOUR_MULT = H_MULT_W'(SEC_PER_HOUR);
   localparam logic [US_MULT_W-1:0] US_MULT   = US_MULT_W'(US_PER_SEC);

   // Token queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE    = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_CONTENT = 2'd2
   } ltp_status_type;

   typedef enum logic [2:0] {
      TK_NUL,
      TK_DIGIT,
      TK_BLANK,
      TK_LBRACK,
      TK_RBRACK,
      TK_COLON,
      TK_DOT,
      TK_OTHER
   } ltp_kind_type;

   typedef enum logic [3:0] {
      PH_WS,
      PH_FIRST,
      PH_HOURS,
      PH_MIN_FIRST,
      PH_MIN,
      PH_SEC_FIRST,
      PH_SEC,
      PH_MS,
      PH_AFTER,
      PH_SKIP,
      PH_DONE,
      PH_CONV
   } ltp_phase_type;

   typedef enum logic [2:0] {
      CV_IDLE,
      CV_MUL_H,
      CV_ADD_MS,
      CV_MUL_US,
      CV_ADD_FRAC,
      CV_DONE
   } ltp_conv_state_type;

   // One classified byte.
   typedef struct packed {
      ltp_kind_type     kind;
      logic [3:0]       digit;
      logic             last;
      logic [POS_W-1:0] pos;
      logic             late;
   } ltp_token_type;

   // Back end to conversion unit.
   typedef struct packed {
      logic            start;
      logic            ack;
      logic [TS_W-1:0] hours;
      logic [5:0]      minutes;
      logic [5:0]      seconds;
      logic [9:0]      millis;
   } ltp_conv_req_type;

   // Conversion unit to back end.
   typedef struct packed {
      logic            done;
      logic            ok;
      logic [TS_W-1:0] value;
   } ltp_conv_rsp_type;

endpackage

// ----- sv/ltp_if.sv -----
// Valid/ready channel interfaces for the request bytes and the parse results.
// Depends on ltp_pkg for the payload widths.
interface ltp_req_if;
   import ltp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] line_byte;
   logic              line_end;

   modport source (output valid, output line_byte, output line_end, input ready);
   modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface ltp_rsp_if;
   import ltp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TS_W-1:0]     stamp_us;
   logic [OFF_W-1:0]    content_offset;

   modport source (output valid, output status, output stamp_us, output content_offset,
                   input ready);
   modport sink   (input valid, input status, input stamp_us, input content_offset,
                   output ready);
endinterface

// ----- sv/ltp_front.sv -----
// Front end: accepts line bytes, classifies them and tracks the byte index.
// Depends on ltp_pkg and ltp_req_if; feeds tokens into ltp_queue.
module ltp_front (
   input  logic                  clock,
   input  logic                  reset,
   ltp_req_if.sink               req_chan,
   input  logic                  queue_full,
   output logic                  push,
   output ltp_pkg::ltp_token_type push_token
);
   import ltp_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [BYTE_W-1:0] b;
   ltp_kind_type      kind;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && req_chan.ready;
   assign b              = req_chan.line_byte;

   // Sort the byte into the classes the parser cares about.
   always_comb begin
      priority if (b == CH_NUL)                       kind = TK_NUL;
      else if (b >= CH_ZERO && b <= CH_NINE)          kind = TK_DIGIT;
      else if (b == CH_SPACE || b == CH_TAB)          kind = TK_BLANK;
      else if (b == CH_LBRACK)                        kind = TK_LBRACK;
      else if (b == CH_RBRACK)                        kind = TK_RBRACK;
      else if (b == CH_COLON)                         kind = TK_COLON;
      else if (b == CH_DOT)                           kind = TK_DOT;
      else                                            kind = TK_OTHER;
   end

   always_comb begin
      push_token.kind  = kind;
      push_token.digit = 4'(b - CH_ZERO);
      push_token.last  = req_chan.line_end;
      push_token.pos   = pos_ff;
      push_token.late  = (pos_ff >= POS_W'(OFFSET_LIMIT));
   end

   // Byte index within the line; saturates once content can no longer be reported.
   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         if (kind == TK_NUL || req_chan.line_end) begin
            pos_in = '0;
         end else if (pos_ff != POS_W'(OFFSET_LIMIT)) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- sv/ltp_queue.sv -----
// Short token queue that decouples the byte front end from the parser back end.
// Depends on ltp_pkg for the token type and depth.
module ltp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ltp_pkg::ltp_token_type push_token,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ltp_pkg::ltp_token_type head_token
);
   import ltp_pkg::*;

   ltp_token_type      entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]  wr_ff;
   logic [QIDX_W-1:0]  wr_in;
   logic [QIDX_W-1:0]  rd_ff;
   logic [QIDX_W-1:0]  rd_in;
   logic [QCNT_W-1:0]  cnt_ff;
   logic [QCNT_W-1:0]  cnt_in;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_token = entry_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? QIDX_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? QIDX_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = QCNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = QCNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Token storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_token;
      end
   end

endmodule

// ----- sv/ltp_conv.sv -----
// Clock-form conversion unit: hours, minutes, seconds and milliseconds to microseconds.
// Shift-add multiplies by the constants one bit per cycle with a sticky 64-bit overflow.
// Depends on ltp_pkg.
module ltp_conv (
   input  logic                     clock,
   input  logic                     reset,
   input  ltp_pkg::ltp_conv_req_type conv_req,
   output ltp_pkg::ltp_conv_rsp_type conv_rsp
);
   import ltp_pkg::*;

   ltp_conv_state_type state_ff;
   ltp_conv_state_type state_in;
   logic [TS_W-1:0]    acc_ff;
   logic [TS_W-1:0]    acc_in;
   logic [TS_W-1:0]    mcand_ff;
   logic [TS_W-1:0]    mcand_in;
   logic               ovf_ff;
   logic               ovf_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [5:0]         min_ff;
   logic [5:0]         min_in;
   logic [5:0]         sec_ff;
   logic [5:0]         sec_in;
   logic [9:0]         ms_ff;
   logic [9:0]         ms_in;

   logic               mul_bit;
   logic [TS_W+1:0]    step;
   logic [TS_W:0]      add_sum;
   logic [H_MULT_W-1:0]  clock_rest;
   logic [US_MULT_W-1:0] frac_us;

   // Multiplier bit for the current Horner step, most significant first.
   always_comb begin
      if (state_ff == CV_MUL_H) begin
         mul_bit = HOUR_MULT[cnt_ff[HIDX_W-1:0]];
      end else begin
         mul_bit = US_MULT[cnt_ff];
      end
      step       = {1'b0, acc_ff, 1'b0} + {2'b00, (mul_bit ? mcand_ff : {TS_W{1'b0}})};
      clock_rest = H_MULT_W'(min_ff) * H_MULT_W'(SEC_PER_MIN) + H_MULT_W'(sec_ff);
      frac_us    = US_MULT_W'(ms_ff) * US_MULT_W'(US_PER_MS);
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      ms_in    = ms_ff;
      add_sum  = '0;

      conv_rsp.done  = 1'b0;
      conv_rsp.ok    = !ovf_ff;
      conv_rsp.value = acc_ff;

      unique case (state_ff)
         CV_IDLE: begin
            if (conv_req.start) begin
               mcand_in = conv_req.hours;
               min_in   = conv_req.minutes;
               sec_in   = conv_req.seconds;
               ms_in    = conv_req.millis;
               acc_in   = '0;
               ovf_in   = 1'b0;
               cnt_in   = CNT_W'(H_MULT_W - 1);
               state_in = CV_MUL_H;
            end
         end
         CV_MUL_H, CV_MUL_US: begin
            acc_in = step[TS_W-1:0];
            ovf_in = ovf_ff || (step[TS_W+1:TS_W] != 2'b00);
            if (cnt_ff == '0) begin
               state_in = (state_ff == CV_MUL_H) ? CV_ADD_MS : CV_ADD_FRAC;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         CV_ADD_MS: begin
            // Whole seconds become the multiplicand of the microsecond scaling.
            add_sum  = {1'b0, acc_ff} + (TS_W + 1)'(clock_rest);
            mcand_in = add_sum[TS_W-1:0];
            ovf_in   = ovf_ff || add_sum[TS_W];
            acc_in   = '0;
            cnt_in   = CNT_W'(US_MULT_W - 1);
            state_in = CV_MUL_US;
         end
         CV_ADD_FRAC: begin
            add_sum  = {1'b0, acc_ff} + (TS_W + 1)'(frac_us);
            acc_in   = add_sum[TS_W-1:0];
            ovf_in   = ovf_ff || add_sum[TS_W];
            state_in = CV_DONE;
         end
         CV_DONE: begin
            conv_rsp.done = 1'b1;
            if (conv_req.ack) begin
               state_in = CV_IDLE;
            end
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      min_ff   <= min_in;
      sec_ff   <= sec_in;
      ms_ff    <= ms_in;
   end

endmodule

// ----- sv/ltp_back.sv -----
// Back end: timestamp prefix state machine and the result output register.
// Depends on ltp_pkg and ltp_rsp_if; takes tokens from ltp_queue and uses ltp_conv.
module ltp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tok_valid,
   input  ltp_pkg::ltp_token_type    tok,
   output logic                      pop,
   output ltp_pkg::ltp_conv_req_type conv_req,
   input  ltp_pkg::ltp_conv_rsp_type conv_rsp,
   ltp_rsp_if.source                 rsp_chan
);
   import ltp_pkg::*;

   ltp_phase_type   phase_ff;
   ltp_phase_type   phase_in;
   logic [TS_W-1:0] hv_ff;
   logic [TS_W-1:0] hv_in;
   logic [5:0]      min_ff;
   logic [5:0]      min_in;
   logic [5:0]      sec_ff;
   logic [5:0]      sec_in;
   logic [9:0]      ms_ff;
   logic [9:0]      ms_in;
   logic [1:0]      dc_ff;
   logic [1:0]      dc_in;
   logic            ftl_ff;
   logic            ftl_in;
   logic            last_ff;
   logic            last_in;

   logic                rsp_valid_ff;
   ltp_status_type      rsp_status_ff;
   logic [TS_W-1:0]     rsp_ts_ff;
   logic [OFF_W-1:0]    rsp_off_ff;

   logic                can_emit;
   logic                emit;
   ltp_status_type      e_status;
   logic [TS_W-1:0]     e_ts;
   logic [OFF_W-1:0]    e_off;
   logic                fail;
   logic                go_conv;
   logic                restart;
   logic [TS_W+3:0]     ten_v;
   logic [9:0]          min_n;
   logic [9:0]          sec_n;
   logic [9:0]          ms_n;

   assign can_emit = !rsp_valid_ff || rsp_chan.ready;

   // Digit accumulation for the first number and the clock fields.
   always_comb begin
      ten_v = {1'b0, hv_ff, 3'b000} + {3'b000, hv_ff, 1'b0} + (TS_W + 4)'(tok.digit);
      min_n = 10'(min_ff) * 10'd10 + 10'(tok.digit);
      sec_n = 10'(sec_ff) * 10'd10 + 10'(tok.digit);
      ms_n  = ms_ff * 10'd10 + 10'(tok.digit);
   end

   // Next phase, field updates and result selection.
   always_comb begin
      phase_in = phase_ff;
      hv_in    = hv_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      ms_in    = ms_ff;
      dc_in    = dc_ff;
      ftl_in   = ftl_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      e_status = ST_NONE;
      e_ts     = '0;
      e_off    = '0;
      fail     = 1'b0;
      go_conv  = 1'b0;
      restart  = 1'b0;

      conv_req.start   = 1'b0;
      conv_req.ack     = 1'b0;
      conv_req.hours   = hv_ff;
      conv_req.minutes = min_ff;
      conv_req.seconds = sec_ff;
      conv_req.millis  = ms_ff;

      if (phase_ff == PH_CONV) begin
         // Wait for the clock total, then finish the closing bracket.
         if (conv_rsp.done && can_emit) begin
            conv_req.ack = 1'b1;
            if (!conv_rsp.ok) begin
               emit     = 1'b1;
               phase_in = PH_DONE;
               restart  = last_ff;
            end else if (last_ff) begin
               emit     = 1'b1;
               e_status = ST_EMPTY;
               e_ts     = conv_rsp.value;
               restart  = 1'b1;
            end else begin
               hv_in    = conv_rsp.value;
               phase_in = PH_AFTER;
            end
         end
      end else if (tok_valid && can_emit) begin
         pop = 1'b1;
         if (tok.kind == TK_NUL) begin
            // A zero byte ends the line.
            if (phase_ff != PH_DONE) begin
               emit = 1'b1;
               if (phase_ff == PH_AFTER || phase_ff == PH_SKIP) begin
                  e_status = ST_EMPTY;
                  e_ts     = hv_ff;
               end
            end
            restart = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_WS: begin
                  if (tok.kind == TK_LBRACK) begin
                     phase_in = PH_FIRST;
                  end else if (tok.kind != TK_BLANK) begin
                     fail = 1'b1;
                  end
               end
               PH_FIRST, PH_HOURS: begin
                  if (tok.kind == TK_DIGIT) begin
                     if (ten_v[TS_W+3:TS_W] != 4'd0) begin
                        fail = 1'b1;
                     end else begin
                        hv_in    = ten_v[TS_W-1:0];
                        phase_in = PH_HOURS;
                     end
                  end else if (phase_ff == PH_HOURS && tok.kind == TK_COLON) begin
                     phase_in = PH_MIN_FIRST;
                  end else if (phase_ff == PH_HOURS && tok.kind == TK_RBRACK) begin
                     phase_in = PH_AFTER;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_MIN_FIRST, PH_MIN: begin
                  if (tok.kind == TK_DIGIT) begin
                     if (!ftl_ff) begin
                        if (min_n >= 10'(CLOCK_FIELD_LIMIT)) begin
                           ftl_in = 1'b1;
                        end else begin
                           min_in = 6'(min_n);
                        end
                     end
                     phase_in = PH_MIN;
                  end else if (phase_ff == PH_MIN && tok.kind == TK_COLON) begin
                     phase_in = PH_SEC_FIRST;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_SEC_FIRST, PH_SEC: begin
                  if (tok.kind == TK_DIGIT) begin
                     if (!ftl_ff) begin
                        if (sec_n >= 10'(CLOCK_FIELD_LIMIT)) begin
                           ftl_in = 1'b1;
                        end else begin
                           sec_in = 6'(sec_n);
                        end
                     end
                     phase_in = PH_SEC;
                  end else if (phase_ff == PH_SEC && tok.kind == TK_DOT) begin
                     phase_in = PH_MS;
                     dc_in    = '0;
                  end else if (phase_ff == PH_SEC && tok.kind == TK_RBRACK) begin
                     fail    = ftl_ff;
                     go_conv = !ftl_ff;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_MS: begin
                  if (tok.kind == TK_DIGIT) begin
                     if (dc_ff == 2'(MS_DIGITS)) begin
                        fail = 1'b1;
                     end else begin
                        ms_in = ms_n;
                        dc_in = dc_ff + 1'b1;
                     end
                  end else if (tok.kind == TK_RBRACK && dc_ff == 2'(MS_DIGITS)) begin
                     fail    = ftl_ff;
                     go_conv = !ftl_ff;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_AFTER: begin
                  if (tok.kind == TK_BLANK) begin
                     phase_in = PH_SKIP;
                  end else begin
                     fail = 1'b1;
                  end
               end
               PH_SKIP: begin
                  // First non-blank byte after the bracket starts the content.
                  if (tok.kind != TK_BLANK) begin
                     if (tok.late) begin
                        fail = 1'b1;
                     end else begin
                        emit     = 1'b1;
                        e_status = ST_CONTENT;
                        e_ts     = hv_ff;
                        e_off    = OFF_W'(tok.pos);
                        phase_in = PH_DONE;
                     end
                  end
               end
               default: begin
                  // Line already decided: bytes are ignored until it ends.
               end
            endcase

            if (fail) begin
               emit     = 1'b1;
               e_status = ST_NONE;
               e_ts     = '0;
               e_off    = '0;
               phase_in = PH_DONE;
            end

            if (go_conv) begin
               phase_in       = PH_CONV;
               conv_req.start = 1'b1;
               last_in        = tok.last;
            end else if (tok.last) begin
               // The flagged last byte closes the line after it is parsed.
               if (!emit && phase_in != PH_DONE) begin
                  emit = 1'b1;
                  if (phase_in == PH_AFTER || phase_in == PH_SKIP) begin
                     e_status = ST_EMPTY;
                     e_ts     = hv_in;
                  end
               end
               restart = 1'b1;
            end
         end
      end

      if (restart) begin
         phase_in = PH_WS;
         hv_in    = '0;
         min_in   = '0;
         sec_in   = '0;
         ms_in    = '0;
         dc_in    = '0;
         ftl_in   = 1'b0;
         last_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
         hv_ff    <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
         ms_ff    <= '0;
         dc_ff    <= '0;
         ftl_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hv_ff    <= hv_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         ms_ff    <= ms_in;
         dc_ff    <= dc_in;
         ftl_ff   <= ftl_in;
         last_ff  <= last_in;
      end
   end

   // Result register: holds a transaction until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_ts_ff     <= e_ts;
         rsp_off_ff    <= e_off;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.stamp_us       = rsp_ts_ff;
   assign rsp_chan.content_offset = rsp_off_ff;

   // The conversion unit only reports while the parser waits for it.
   a_conv_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_rsp.done |-> phase_ff == PH_CONV)
      else $error("conversion result outside the conversion phase");

   // A conversion starts only from a closing bracket of the clock form.
   a_conv_start_phase: assert property (@(posedge clock) disable iff (reset)
      conv_req.start |-> (phase_ff == PH_SEC || phase_ff == PH_MS))
      else $error("conversion started outside the seconds or millisecond phase");

   // Once a result is produced the line is finished or restarted.
   a_emit_closes_line: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_DONE || phase_ff == PH_WS))
      else $error("parser kept running after deciding a line");

   // A result without a timestamp carries zero payload.
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NONE) |-> (rsp_ts_ff == '0 && rsp_off_ff == '0))
      else $error("status none with nonzero payload");

endmodule

// ----- sv/log_timestamp_prefix_parser.sv -----
// Channel     Dir  Handshake      Payload
// req_chan    in   valid/ready    line_byte[7:0], line_end
// rsp_chan    out  valid/ready    status[1:0], stamp_us[63:0], content_offset[11:0]
//
// Bytes are accepted one per cycle while the four-entry token queue has room.
// The back end parses one byte per cycle while the result register can take a result;
// a clock-form closing bracket stalls it in the shift-add conversion unit (12 + 20 multiply
// steps, two add steps and the handoff).
// Synchronous reset clears the parser, queue pointers and result valid; no clearing pass.
// A stalled result register holds the back end, and the queue then holds the front end.
// Top level of the log timestamp prefix parser; depends on ltp_pkg, ltp_if and submodules.
module log_timestamp_prefix_parser (
   input  logic      clock,
   input  logic      reset,
   ltp_req_if.sink   req_chan,
   ltp_rsp_if.source rsp_chan
);
   import ltp_pkg::*;

   logic             push;
   ltp_token_type    push_token;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   ltp_token_type    head_token;
   ltp_conv_req_type conv_req;
   ltp_conv_rsp_type conv_rsp;

   ltp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_token (push_token)
   );

   ltp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   ltp_conv u_conv (
      .clock    (clock),
      .reset    (reset),
      .conv_req (conv_req),
      .conv_rsp (conv_rsp)
   );

   ltp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (head_valid),
      .tok       (head_token),
      .pop       (pop),
      .conv_req  (conv_req),
      .conv_rsp  (conv_rsp),
      .rsp_chan  (rsp_chan)
   );

endmodule
